// ===== hw/rtl/wsdf_pkg.sv =====
package wsdf_pkg;

    // Frame parse phase
    typedef enum logic [2:0] {
        PH_HDR0   = 3'd0,
        PH_HDR1   = 3'd1,
        PH_EXTLEN = 3'd2,
        PH_KEY    = 3'd3,
        PH_DATA   = 3'd4,
        PH_DROP   = 3'd5
    } t_phase;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_CLOSE   = 2'd2;

    // Header constants
    localparam logic [3:0] OPC_CLOSE    = 4'h8;
    localparam logic [6:0] LEN_CODE_16  = 7'd126;
    localparam logic [6:0] LEN_CODE_64  = 7'd127;
    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_64 = 4'd8;
    localparam logic [3:0] KEY_BYTES    = 4'd4;

endpackage

// ===== hw/rtl/websocket_frame_deframer.sv =====
// A request's result is on the output register in the cycle after the byte is taken.
// Throughput: one byte per cycle; the input is ready whenever the output register is
// empty or is being taken in the same cycle.
// Close payload gives no result; header bytes none but last of a close or empty header.
// Reset (i_rst_n low, synchronous) returns the parser to the first header byte and
// empties the output register.
module websocket_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [3:0]  o_opcode,
    output logic        o_fin,
    output logic        o_masked,
    output logic [31:0] o_payload_length,
    output logic        o_last
);

    // Parser state
    wsdf_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_count, n_count;
    logic             r_ext_long, n_ext_long;
    logic             r_fin, n_fin;
    logic [3:0]       r_opcode, n_opcode;
    logic             r_mask, n_mask;
    logic [31:0]      r_length, n_length;
    logic [31:0]      r_key, n_key;
    logic [31:0]      r_pos, n_pos;

    // Output register
    logic             r_out_valid;
    logic [1:0]       r_kind;
    logic [7:0]       r_pbyte;
    logic [3:0]       r_out_opcode;
    logic             r_out_fin;
    logic             r_out_mask;
    logic [31:0]      r_out_length;
    logic             r_out_last;

    // Per-byte decode
    logic             w_accept;
    logic             w_hdr_done;
    logic [3:0]       w_count_inc;
    logic [3:0]       w_ext_total;
    logic [31:0]      w_pos_inc;
    logic [7:0]       w_key_byte;
    logic             w_data_last;

    // Result of this byte
    logic             w_res;
    logic [1:0]       w_res_kind;
    logic [7:0]       w_res_byte;
    logic             w_res_last;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_count_inc = r_count + 4'd1;
    assign w_ext_total = r_ext_long ? wsdf_pkg::EXT_BYTES_64 : wsdf_pkg::EXT_BYTES_16;
    assign w_pos_inc   = r_pos + 32'd1;
    assign w_data_last = (r_pos == (r_length - 32'd1));

    // Mask key byte for position mod 4, first key byte first
    always_comb begin
        case (r_pos[1:0])
            2'd0:    w_key_byte = r_key[31:24];
            2'd1:    w_key_byte = r_key[23:16];
            2'd2:    w_key_byte = r_key[15:8];
            default: w_key_byte = r_key[7:0];
        endcase
    end

    // Next state
    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_ext_long = r_ext_long;
        n_fin      = r_fin;
        n_opcode   = r_opcode;
        n_mask     = r_mask;
        n_length   = r_length;
        n_key      = r_key;
        n_pos      = r_pos;
        w_hdr_done = 1'b0;

        case (r_phase)
            wsdf_pkg::PH_HDR1: begin
                n_mask   = i_in_byte[7];
                n_count  = 4'd0;
                n_length = 32'd0;
                if (i_in_byte[6:0] < wsdf_pkg::LEN_CODE_16) begin
                    n_length = {25'd0, i_in_byte[6:0]};
                    if (i_in_byte[7]) begin
                        n_phase = wsdf_pkg::PH_KEY;
                    end else begin
                        w_hdr_done = 1'b1;
                    end
                end else begin
                    n_ext_long = (i_in_byte[6:0] == wsdf_pkg::LEN_CODE_64);
                    n_phase    = wsdf_pkg::PH_EXTLEN;
                end
            end
            wsdf_pkg::PH_EXTLEN: begin
                // 64-bit lengths keep only the last four bytes
                n_length = {r_length[23:0], i_in_byte};
                n_count  = w_count_inc;
                if (w_count_inc >= w_ext_total) begin
                    n_count = 4'd0;
                    if (r_mask) begin
                        n_phase = wsdf_pkg::PH_KEY;
                    end else begin
                        w_hdr_done = 1'b1;
                    end
                end
            end
            wsdf_pkg::PH_KEY: begin
                n_key   = {r_key[23:0], i_in_byte};
                n_count = w_count_inc;
                if (w_count_inc >= wsdf_pkg::KEY_BYTES) begin
                    w_hdr_done = 1'b1;
                end
            end
            wsdf_pkg::PH_DATA: begin
                n_pos = w_pos_inc;
                if (w_data_last) begin
                    n_phase = wsdf_pkg::PH_HDR0;
                end
            end
            wsdf_pkg::PH_DROP: begin
                n_pos = w_pos_inc;
                if (w_pos_inc >= r_length) begin
                    n_phase = wsdf_pkg::PH_HDR0;
                end
            end
            default: begin
                // First header byte; unused codes land here too
                n_fin    = i_in_byte[7];
                n_opcode = i_in_byte[3:0];
                n_mask   = 1'b0;
                n_key    = 32'd0;
                n_length = 32'd0;
                n_pos    = 32'd0;
                n_count  = 4'd0;
                n_phase  = wsdf_pkg::PH_HDR1;
            end
        endcase

        // End of header: close frames drop their payload, empty frames end here
        if (w_hdr_done) begin
            n_pos = 32'd0;
            if (n_opcode == wsdf_pkg::OPC_CLOSE) begin
                n_phase = (n_length == 32'd0) ? wsdf_pkg::PH_HDR0 : wsdf_pkg::PH_DROP;
            end else if (n_length == 32'd0) begin
                n_phase = wsdf_pkg::PH_HDR0;
            end else begin
                n_phase = wsdf_pkg::PH_DATA;
            end
        end
    end

    // Result of the byte
    always_comb begin
        w_res      = 1'b0;
        w_res_kind = wsdf_pkg::KIND_PAYLOAD;
        w_res_byte = 8'd0;
        w_res_last = 1'b1;
        if (r_phase == wsdf_pkg::PH_DATA) begin
            w_res      = 1'b1;
            w_res_byte = i_in_byte ^ w_key_byte;
            w_res_last = w_data_last;
        end else if (w_hdr_done) begin
            if (n_opcode == wsdf_pkg::OPC_CLOSE) begin
                w_res      = 1'b1;
                w_res_kind = wsdf_pkg::KIND_CLOSE;
            end else if (n_length == 32'd0) begin
                w_res      = 1'b1;
                w_res_kind = wsdf_pkg::KIND_EMPTY;
            end
        end
    end

    // Parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= wsdf_pkg::PH_HDR0;
            r_count    <= 4'd0;
            r_ext_long <= 1'b0;
            r_fin      <= 1'b0;
            r_opcode   <= 4'd0;
            r_mask     <= 1'b0;
            r_length   <= 32'd0;
            r_key      <= 32'd0;
            r_pos      <= 32'd0;
        end else if (w_accept) begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_ext_long <= n_ext_long;
            r_fin      <= n_fin;
            r_opcode   <= n_opcode;
            r_mask     <= n_mask;
            r_length   <= n_length;
            r_key      <= n_key;
            r_pos      <= n_pos;
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_accept && w_res) begin
            r_kind       <= w_res_kind;
            r_pbyte      <= w_res_byte;
            r_out_opcode <= n_opcode;
            r_out_fin    <= n_fin;
            r_out_mask   <= n_mask;
            r_out_length <= n_length;
            r_out_last   <= w_res_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_payload_byte   = r_pbyte;
    assign o_opcode         = r_out_opcode;
    assign o_fin            = r_out_fin;
    assign o_masked         = r_out_mask;
    assign o_payload_length = r_out_length;
    assign o_last           = r_out_last;

endmodule
